/* hw/rtl/cid_pkg.sv */
// cid_pkg: shared widths, request/result structs and lane control for the
// cubic interpolating delay line. No dependencies.
package cid_pkg;

  // fixed sample and distance formats
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 8;
  localparam int DIST_BITS    = 23;
  // horner accumulator, headroom for the doubled cubic coefficients
  localparam int ACC_BITS     = SAMPLE_BITS + 8;
  localparam int TAP_COUNT    = 4;
  localparam int TAP_IDX_BITS = 2;

  // request operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic [FRAC_BITS-1:0]          frac_t;

  typedef struct packed {
    logic                 operation;
    logic [DIST_BITS-1:0] read_distance;
    sample_t              write_left;
    sample_t              write_right;
  } in_req_t;

  typedef struct packed {
    sample_t delayed_left;
    sample_t delayed_right;
  } out_res_t;

  // per-cycle lane operation
  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_COEF,
    LOP_STEP3,
    LOP_STEP2,
    LOP_STEP1
  } lane_op_e;

  typedef struct packed {
    logic                    wr;
    logic                    rd;
    logic [TAP_IDX_BITS-1:0] tap;
    logic                    live;
    lane_op_e                op;
  } lane_ctl_t;

endpackage

/* hw/rtl/cid_ram.sv */
// cid_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
module cid_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cid_lane.sv */
// cid_lane: one channel of the delay line, sample ram, four-tap capture,
// catmull-rom coefficients and a shared horner multiply-add. Uses cid_pkg, cid_ram.
module cid_lane import cid_pkg::*; #(
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  logic [AW-1:0] waddr_i,
  input  sample_t   wdata_i,
  input  logic [AW-1:0] raddr_i,
  input  frac_t     frac_i,
  output acc_t      acc_o
);

  logic [SAMPLE_BITS-1:0]  rdata;
  logic                    rd_q;
  logic                    live_q;
  logic [TAP_IDX_BITS-1:0] tap_q;
  sample_t                 y_q [TAP_COUNT];
  acc_t                    c0_q, c1_q, c2_q, c3_q, t_q;
  acc_t                    y0, y1, y2, y3, d12;
  acc_t                    mul_src, add_src, step_d;
  logic signed [ACC_BITS+FRAC_BITS:0] prod;

  cid_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (ctl_i.rd),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  // read data lands in the cycle after the address, track which tap it is
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= 1'b0;
      live_q <= 1'b0;
      tap_q  <= '0;
    end else begin
      rd_q   <= ctl_i.rd;
      live_q <= ctl_i.live;
      tap_q  <= ctl_i.tap;
    end
  end

  // taps widened to the accumulator
  assign y0  = acc_t'(y_q[0]);
  assign y1  = acc_t'(y_q[1]);
  assign y2  = acc_t'(y_q[2]);
  assign y3  = acc_t'(y_q[3]);
  assign d12 = y1 - y2;

  // horner operand select
  always_comb begin
    mul_src = t_q;
    add_src = c0_q;
    case (ctl_i.op)
      LOP_STEP3: begin
        mul_src = c3_q;
        add_src = c2_q;
      end
      LOP_STEP2: add_src = c1_q;
      default: ;
    endcase
  end

  // t * f then floor shift by the fraction width
  assign prod   = mul_src * $signed({1'b0, frac_i});
  assign step_d = acc_t'(prod >>> FRAC_BITS) + add_src;

  // tap capture, coefficient and horner registers
  always_ff @(posedge clk_i) begin
    if (rd_q) begin
      y_q[tap_q] <= live_q ? $signed(rdata) : '0;
    end
    case (ctl_i.op)
      LOP_COEF: begin
        c0_q <= y1 <<< 1;
        c1_q <= y2 - y0;
        c2_q <= (y0 <<< 1) - (y1 <<< 2) - y1 + (y2 <<< 2) - y3;
        c3_q <= (y3 - y0) + (d12 <<< 1) + d12;
      end
      LOP_STEP3, LOP_STEP2, LOP_STEP1: t_q <= step_d;
      default: ;
    endcase
  end

  assign acc_o = t_q;

endmodule

/* hw/rtl/cubic_interp_delay_line.sv */
// Write request: the next request is taken in the following cycle.
// Read request: the input stalls until the result is registered; the steps are
// position, four taps through the single ram read port, tap drain,
// coefficient, three horner steps and rounding. Too little history: zero result
// from position straight to rounding. A stalled earlier result holds rounding.
// Reset clears pointers, fill count and control; unwritten ram entries read as zero.
module cubic_interp_delay_line import cid_pkg::*; #(
  parameter int DEPTH    = 32768,
  parameter int CHANNELS = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_res_t out_res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int PW = ((AW + FRAC_BITS) > DIST_BITS ? (AW + FRAC_BITS) : DIST_BITS) + 2;
  localparam int RIGHT_LANE = 1 % CHANNELS;
  localparam logic [PW-1:0] RING_SPAN  = PW'(DEPTH) << FRAC_BITS;
  localparam logic [PW-1:0] ONE_STEP   = PW'(1) << FRAC_BITS;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL_COUNT = FW'(DEPTH);
  localparam logic signed [ACC_BITS:0] SAT_MAX = (ACC_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [ACC_BITS:0] RND_ONE = (ACC_BITS+1)'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_TAPS,
    ST_LAST,
    ST_COEF,
    ST_STEP3,
    ST_STEP2,
    ST_STEP1,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [AW-1:0]           wp_q;
  logic [FW-1:0]           fill_q;
  logic [DIST_BITS-1:0]    dist_q;
  logic [AW-1:0]           addr_q;
  frac_t                   frac_q;
  logic [TAP_IDX_BITS-1:0] tap_q;
  logic                    ok_q;
  logic                    out_valid_q;
  out_res_t                out_res_q;

  logic          in_take;
  logic          full;
  logic [PW-1:0] diff, pos;
  logic          hist_ok;
  logic [AW-1:0] i1, first_addr, next_addr;
  logic          tap_live;
  lane_ctl_t     lane_ctl;
  out_res_t      merged;
  acc_t          lane_acc [CHANNELS];

  // halve with round half up, then clamp to the sample range
  function automatic sample_t round_sat(acc_t t);
    logic signed [ACC_BITS:0] half;
    half = ($signed({t[ACC_BITS-1], t}) + RND_ONE) >>> 1;
    if (half > SAT_MAX) begin
      return SAT_MAX[SAMPLE_BITS-1:0];
    end else if (half < SAT_MIN) begin
      return SAT_MIN[SAMPLE_BITS-1:0];
    end
    return half[SAMPLE_BITS-1:0];
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign full       = (fill_q == FULL_COUNT);

  // read position behind the write pointer, wrapped once into the ring
  assign diff    = PW'({wp_q, {FRAC_BITS{1'b0}}}) - PW'(dist_q);
  assign pos     = diff[PW-1] ? diff + RING_SPAN : diff;
  assign hist_ok = (PW'(dist_q) + ONE_STEP) <= (PW'(fill_q) << FRAC_BITS);
  assign i1      = pos[AW+FRAC_BITS-1:FRAC_BITS];

  // tap addresses walk from i1-1 to i1+2 with wrap
  assign first_addr = (i1 == '0) ? LAST_ADDR : i1 - AW'(1);
  assign next_addr  = (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
  assign tap_live   = full || (FW'(addr_q) < fill_q);

  // lane control
  always_comb begin
    lane_ctl      = '0;
    lane_ctl.wr   = in_take && (in_req_i.operation == OP_WRITE);
    lane_ctl.rd   = (state_q == ST_TAPS);
    lane_ctl.tap  = tap_q;
    lane_ctl.live = tap_live;
    case (state_q)
      ST_COEF:  lane_ctl.op = LOP_COEF;
      ST_STEP3: lane_ctl.op = LOP_STEP3;
      ST_STEP2: lane_ctl.op = LOP_STEP2;
      ST_STEP1: lane_ctl.op = LOP_STEP1;
      default:  lane_ctl.op = LOP_NONE;
    endcase
  end

  // one lane per channel, even channels take left, odd take right
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    cid_lane #(
      .DEPTH (DEPTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (lane_ctl),
      .waddr_i (wp_q),
      .wdata_i ((c % 2 == 0) ? in_req_i.write_left : in_req_i.write_right),
      .raddr_i (addr_q),
      .frac_i  (frac_q),
      .acc_o   (lane_acc[c])
    );
  end

  // merge lanes into the result, zero when history is short
  always_comb begin
    merged.delayed_left  = ok_q ? round_sat(lane_acc[0]) : '0;
    merged.delayed_right = ok_q ? round_sat(lane_acc[RIGHT_LANE]) : '0;
  end

  // sequencer, ring pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      dist_q      <= '0;
      addr_q      <= '0;
      frac_q      <= '0;
      tap_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      // result taken, unless the final stage reloads it
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            if (in_req_i.operation == OP_WRITE) begin
              wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
              if (!full) begin
                fill_q <= fill_q + FW'(1);
              end
            end else begin
              dist_q  <= in_req_i.read_distance;
              state_q <= ST_POS;
            end
          end
        end
        ST_POS: begin
          ok_q    <= hist_ok;
          addr_q  <= first_addr;
          frac_q  <= pos[FRAC_BITS-1:0];
          tap_q   <= '0;
          state_q <= hist_ok ? ST_TAPS : ST_DONE;
        end
        ST_TAPS: begin
          addr_q <= next_addr;
          tap_q  <= tap_q + TAP_IDX_BITS'(1);
          if (tap_q == TAP_IDX_BITS'(TAP_COUNT - 1)) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST:  state_q <= ST_COEF;
        ST_COEF:  state_q <= ST_STEP3;
        ST_STEP3: state_q <= ST_STEP2;
        ST_STEP2: state_q <= ST_STEP1;
        ST_STEP1: state_q <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_res_q   <= merged;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // fill count never passes the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FULL_COUNT)
    else $error("fill count above depth");

  // until the ring wraps the write pointer equals the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (FW'(wp_q) == fill_q))
    else $error("write pointer out of step with fill count");

  // an accepted read starts the position stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_req_i.operation == OP_READ) |=> (state_q == ST_POS))
    else $error("read request not started");

  // tap counter is parked outside the tap phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_TAPS) |-> (tap_q == '0))
    else $error("tap counter not parked");

  // a new result comes only out of the final stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside final stage");

endmodule

/* dv/cubic_interp_delay_line_tb.sv */
// cubic_interp_delay_line_tb: self-checking bench for the stereo catmull-rom delay line,
// with a bit-exact line predictor, directed and random request traffic, random idling
// depends on cid_pkg and cubic_interp_delay_line
module cubic_interp_delay_line_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cid_pkg::*;

  localparam int DEPTH          = 32768;
  localparam int CLK_PERIOD     = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_TAIL     = 40;
  localparam int PHASE_LEN      = 100;

  localparam longint unsigned ONE_SAMPLE = 64'd1 << FRAC_BITS;
  localparam longint unsigned RING_SPAN  = 64'(DEPTH) << FRAC_BITS;
  localparam longint SAT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;
  localparam sample_t FULL_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t FULL_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // idling schedule: none, sender only, receiver only, both lightly
  localparam int IDLE_SCHED  [4] = '{0, 69, 0, 9};
  localparam int STALL_SCHED [4] = '{0, 0, 69, 9};

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_res_t out_res_o;

  // predictor state: mirrored sample rings, write position and fill count
  sample_t     line_left  [DEPTH];
  sample_t     line_right [DEPTH];
  int unsigned line_wr_pos;
  int unsigned line_fill;
  out_res_t    interp_due_q [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int quiet_cycles   = 0;

  cubic_interp_delay_line dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // four-tap catmull-rom with doubled integer coefficients and floored horner steps
  function automatic sample_t catmull_rom(input logic right_ch, input int unsigned i1,
                                          input longint frac);
    longint y0, y1, y2, y3;
    longint c0, c1, c2, c3, acc;
    int unsigned k0, k1, k2, k3;
    k0 = (i1 + DEPTH - 1) % DEPTH;
    k1 = i1 % DEPTH;
    k2 = (i1 + 1) % DEPTH;
    k3 = (i1 + 2) % DEPTH;
    if (right_ch) begin
      y0 = line_right[k0]; y1 = line_right[k1]; y2 = line_right[k2]; y3 = line_right[k3];
    end else begin
      y0 = line_left[k0];  y1 = line_left[k1];  y2 = line_left[k2];  y3 = line_left[k3];
    end
    c0  = 2 * y1;
    c1  = y2 - y0;
    c2  = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    c3  = (y3 - y0) + 3 * (y1 - y2);
    acc = c3;
    acc = ((acc * frac) >>> FRAC_BITS) + c2;
    acc = ((acc * frac) >>> FRAC_BITS) + c1;
    acc = ((acc * frac) >>> FRAC_BITS) + c0;
    // round half up, then clamp to the sample range
    acc = (acc + 1) >>> 1;
    if (acc > SAT_MAX) acc = SAT_MAX;
    if (acc < SAT_MIN) acc = SAT_MIN;
    return sample_t'(acc);
  endfunction

  // update the mirrored line for one accepted request, queue the read result
  function automatic void predict_request(input in_req_t r);
    longint unsigned rd_dist, pos;
    int unsigned     i1;
    longint          frac;
    out_res_t        res;
    if (r.operation == OP_WRITE) begin
      line_left[line_wr_pos]  = r.write_left;
      line_right[line_wr_pos] = r.write_right;
      line_wr_pos = (line_wr_pos + 1) % DEPTH;
      if (line_fill < DEPTH) line_fill++;
    end else begin
      rd_dist = r.read_distance;
      res     = '0;
      // not enough history reads as silence
      if (rd_dist + ONE_SAMPLE <= (64'(line_fill) << FRAC_BITS)) begin
        pos  = ((64'(line_wr_pos) << FRAC_BITS) + RING_SPAN - (rd_dist % RING_SPAN))
               % RING_SPAN;
        i1   = int'(pos >> FRAC_BITS);
        frac = longint'(pos & (ONE_SAMPLE - 1));
        res.delayed_left  = catmull_rom(1'b0, i1, frac);
        res.delayed_right = catmull_rom(1'b1, i1, frac);
      end
      interp_due_q.push_back(res);
    end
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return sample_t'(int'($urandom_range(4000)) - 2000);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // mostly distances inside the written history, some anywhere in the field
  function automatic logic [DIST_BITS-1:0] rand_distance();
    int unsigned reach;
    if (line_fill == 0 || $urandom_range(99) < 15) return DIST_BITS'($urandom());
    reach = (line_fill - 1) << FRAC_BITS;
    case ($urandom_range(9))
      0:       return DIST_BITS'(reach);
      1:       return DIST_BITS'(reach + 1);
      default: return DIST_BITS'($urandom_range(reach, 0));
    endcase
  endfunction

  // unused fields carry random junk so they are seen to be ignored
  function automatic in_req_t write_req(input sample_t l, input sample_t r);
    in_req_t q;
    q.operation     = OP_WRITE;
    q.read_distance = DIST_BITS'($urandom());
    q.write_left    = l;
    q.write_right   = r;
    return q;
  endfunction

  function automatic in_req_t read_req(input logic [DIST_BITS-1:0] d);
    in_req_t q;
    q.operation     = OP_READ;
    q.read_distance = d;
    q.write_left    = sample_t'($urandom());
    q.write_right   = sample_t'($urandom());
    return q;
  endfunction

  task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // present one request, hold it until accepted, then predict
  task automatic send_request(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(r);
  endtask

  // lower valid and wait for every queued read result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (interp_due_q.size() != 0) @(posedge clk_i);
  endtask

  // reads with nothing written, including the largest distance
  task automatic test_empty_reads();
    set_idling(0, 0);
    send_request(read_req('0));
    send_request(read_req(DIST_BITS'(255)));
    send_request(read_req(DIST_BITS'(1) << (DIST_BITS - 1)));
    send_request(read_req({DIST_BITS{1'b1}}));
    drain_results();
  endtask

  // full-scale alternating samples push the cubic past both rails,
  // plus fraction extremes, the exact history limit and reads past the write head
  task automatic test_overshoot_saturation();
    set_idling(0, 0);
    send_request(write_req(FULL_NEG, FULL_POS));
    send_request(write_req(FULL_POS, FULL_NEG));
    send_request(write_req(FULL_POS, FULL_NEG));
    send_request(write_req(FULL_NEG, FULL_POS));
    send_request(read_req(DIST_BITS'(640)));
    send_request(read_req(DIST_BITS'(768)));
    send_request(read_req(DIST_BITS'(769)));
    send_request(read_req(DIST_BITS'(767)));
    send_request(read_req(DIST_BITS'(513)));
    send_request(read_req(DIST_BITS'(896)));
    send_request(read_req('0));
    send_request(write_req(FULL_POS, FULL_NEG));
    send_request(write_req(FULL_NEG, FULL_POS));
    send_request(write_req(FULL_NEG, FULL_POS));
    send_request(write_req(FULL_POS, FULL_NEG));
    send_request(read_req(DIST_BITS'(640)));
    send_request(read_req(DIST_BITS'(1792)));
    drain_results();
  endtask

  // mixed reads and writes through the idling schedule
  task automatic test_random_traffic(input int count);
    in_req_t r;
    for (int i = 0; i < count; i++) begin
      set_idling(IDLE_SCHED[(i / PHASE_LEN) % 4], STALL_SCHED[(i / PHASE_LEN) % 4]);
      if ($urandom_range(1) == 1) r = write_req(rand_sample(), rand_sample());
      else r = read_req(rand_distance());
      send_request(r);
    end
    drain_results();
  endtask

  // extend the history, then read at the far end of it and just past it
  task automatic test_history_edge();
    logic [DIST_BITS-1:0] far_reads [9];
    int unsigned          reach;
    set_idling(0, 0);
    for (int i = 0; i < 100; i++) send_request(write_req(rand_sample(), rand_sample()));
    reach = (line_fill - 1) << FRAC_BITS;
    far_reads = '{
      DIST_BITS'(0),
      DIST_BITS'(reach),
      DIST_BITS'(reach + 1),
      {DIST_BITS{1'b1}},
      DIST_BITS'(reach - 128),
      DIST_BITS'((99 << FRAC_BITS) + 128),
      DIST_BITS'(100 << FRAC_BITS),
      DIST_BITS'((100 << FRAC_BITS) + 255),
      DIST_BITS'(1) << (DIST_BITS - 1)
    };
    set_idling(9, 9);
    foreach (far_reads[k]) send_request(read_req(far_reads[k]));
    drain_results();
  endtask

  // result checker with random receiver stalls
  always @(posedge clk_i) begin
    out_res_t want;
    if (out_valid_o && !out_stall_i) begin
      if (interp_due_q.size() == 0) begin
        report_mismatch("unexpected delayed_left", out_res_o.delayed_left, '0);
      end else begin
        want = interp_due_q.pop_front();
        if (out_res_o.delayed_left !== want.delayed_left)
          report_mismatch("delayed_left", out_res_o.delayed_left, want.delayed_left);
        if (out_res_o.delayed_right !== want.delayed_right)
          report_mismatch("delayed_right", out_res_o.delayed_right, want.delayed_right);
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cubic_interp_delay_line regression: fail");
      $finish;
    end
  end

  initial begin
    foreach (line_left[k]) begin
      line_left[k]  = '0;
      line_right[k] = '0;
    end
    line_wr_pos = 0;
    line_fill   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_overshoot_saturation();
    test_random_traffic(500);
    test_history_edge();
    test_random_traffic(620);

    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatch_count == 0 && interp_due_q.size() == 0) begin
      $display("cubic_interp_delay_line regression: pass");
    end else begin
      $display("cubic_interp_delay_line regression: fail");
    end
    $finish;
  end

endmodule
